### hw/rtl/ps2a_pkg.sv
package ps2a_pkg;

  localparam logic [7:0] ScPrefix  = 8'hE0;
  localparam logic [7:0] ScKpDel   = 8'h53;
  localparam logic [6:0] ScLShift  = 7'd42;
  localparam logic [6:0] ScRShift  = 7'd54;
  localparam logic [6:0] ScCaps    = 7'd58;
  localparam logic [6:0] ChBackspc = 7'h08;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [6:0] ch;
  } op_t;

  // US layout, unshifted; zero means no character
  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] ch;
    ch = 7'h00;
    case (code)
      7'd1:  ch = 7'h1B;
      7'd2:  ch = 7'h31;
      7'd3:  ch = 7'h32;
      7'd4:  ch = 7'h33;
      7'd5:  ch = 7'h34;
      7'd6:  ch = 7'h35;
      7'd7:  ch = 7'h36;
      7'd8:  ch = 7'h37;
      7'd9:  ch = 7'h38;
      7'd10: ch = 7'h39;
      7'd11: ch = 7'h30;
      7'd12: ch = 7'h2D;
      7'd13: ch = 7'h3D;
      7'd14: ch = 7'h08;
      7'd15: ch = 7'h09;
      7'd16: ch = 7'h71;
      7'd17: ch = 7'h77;
      7'd18: ch = 7'h65;
      7'd19: ch = 7'h72;
      7'd20: ch = 7'h74;
      7'd21: ch = 7'h79;
      7'd22: ch = 7'h75;
      7'd23: ch = 7'h69;
      7'd24: ch = 7'h6F;
      7'd25: ch = 7'h70;
      7'd26: ch = 7'h5B;
      7'd27: ch = 7'h5D;
      7'd28: ch = 7'h0A;
      7'd30: ch = 7'h61;
      7'd31: ch = 7'h73;
      7'd32: ch = 7'h64;
      7'd33: ch = 7'h66;
      7'd34: ch = 7'h67;
      7'd35: ch = 7'h68;
      7'd36: ch = 7'h6A;
      7'd37: ch = 7'h6B;
      7'd38: ch = 7'h6C;
      7'd39: ch = 7'h3B;
      7'd40: ch = 7'h27;
      7'd41: ch = 7'h60;
      7'd43: ch = 7'h5C;
      7'd44: ch = 7'h7A;
      7'd45: ch = 7'h78;
      7'd46: ch = 7'h63;
      7'd47: ch = 7'h76;
      7'd48: ch = 7'h62;
      7'd49: ch = 7'h6E;
      7'd50: ch = 7'h6D;
      7'd51: ch = 7'h2C;
      7'd52: ch = 7'h2E;
      7'd53: ch = 7'h2F;
      7'd55: ch = 7'h2A;
      7'd57: ch = 7'h20;
      7'd71: ch = 7'h37;
      7'd72: ch = 7'h38;
      7'd73: ch = 7'h39;
      7'd74: ch = 7'h2D;
      7'd75: ch = 7'h34;
      7'd76: ch = 7'h35;
      7'd77: ch = 7'h36;
      7'd78: ch = 7'h2B;
      7'd79: ch = 7'h31;
      7'd80: ch = 7'h32;
      7'd81: ch = 7'h33;
      7'd82: ch = 7'h30;
      7'd83: ch = 7'h2E;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // top-row digits only; keypad digits keep their plain form
  function automatic logic [6:0] shift_digit(input logic [6:0] code, input logic [6:0] ch);
    logic [6:0] r;
    r = ch;
    case (code)
      7'd2:  r = 7'h21;
      7'd3:  r = 7'h40;
      7'd4:  r = 7'h23;
      7'd5:  r = 7'h24;
      7'd6:  r = 7'h25;
      7'd7:  r = 7'h5E;
      7'd8:  r = 7'h26;
      7'd9:  r = 7'h2A;
      7'd10: r = 7'h28;
      7'd11: r = 7'h29;
      default: r = ch;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/ps2a_front.sv
module ps2a_front import ps2a_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic       cmd_i,
  input  logic [7:0] scan_byte_i,
  output op_t        op_o
);

  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic prefix_q, prefix_d;
  logic [6:0] low7;
  logic [6:0] plain;

  assign low7  = scan_byte_i[6:0];
  assign plain = plain_char(low7);

  always_comb begin
    op_o.kind = OP_NONE;
    op_o.ch   = 7'h00;
    shift_d   = shift_q;
    caps_d    = caps_q;
    prefix_d  = prefix_q;
    if (cmd_i) begin
      op_o.kind = OP_POP;
    end else if (scan_byte_i == ScPrefix) begin
      prefix_d = 1'b1;
    end else if (scan_byte_i[7]) begin
      prefix_d = 1'b0;
      if (low7 == ScLShift || low7 == ScRShift) begin
        shift_d = 1'b0;
      end
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if (scan_byte_i == ScKpDel) begin
        op_o.kind = OP_PUSH;
        op_o.ch   = ChBackspc;
      end
    end else if (low7 == ScLShift || low7 == ScRShift) begin
      shift_d = 1'b1;
    end else if (low7 == ScCaps) begin
      caps_d = ~caps_q;
    end else if (plain != 7'h00) begin
      op_o.kind = OP_PUSH;
      op_o.ch   = plain;
      if (plain >= 7'h61 && plain <= 7'h7A) begin
        if (shift_q ^ caps_q) begin
          op_o.ch = plain - 7'h20;
        end
      end else if (plain >= 7'h30 && plain <= 7'h39) begin
        if (shift_q) begin
          op_o.ch = shift_digit(low7, plain);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (take_i) begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

### hw/rtl/ps2a_queue.sv
module ps2a_queue import ps2a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic nonempty_o,
  output op_t  op_o
);

  op_t        slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign nonempty_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### hw/rtl/ps2a_back.sv
module ps2a_back import ps2a_pkg::*; #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_take_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] char_code_o,
  output logic       overflow_o,
  output logic [8:0] fill_level_o
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int EXT_W = CNT_W + 9;
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(FIFO_DEPTH);

  logic [6:0]       mem_q [FIFO_DEPTH];
  logic [6:0]       rdata_q;
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [EXT_W-1:0] cnt_ext;
  logic             out_valid_q, char_valid_q, ovf_q;
  logic [8:0]       fill_q;
  logic             do_push, do_pop, ovf_d;

  assign op_take_o = op_valid_i && (!out_valid_q || !out_stall_i);
  assign do_pop    = op_take_o && (op_i.kind == OP_POP) && (cnt_q != '0);
  assign do_push   = op_take_o && (op_i.kind == OP_PUSH) && (cnt_q != CntFull);
  assign ovf_d     = (op_i.kind == OP_PUSH) && (cnt_q == CntFull);

  always_comb begin
    cnt_d = cnt_q;
    if (do_push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  assign cnt_ext = EXT_W'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= op_i.ch;
    end
    if (do_pop) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      rp_q         <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      char_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
      fill_q       <= 9'd0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PtrLast) ? '0 : wp_q + PTR_W'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PtrLast) ? '0 : rp_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
      if (op_take_o) begin
        out_valid_q  <= 1'b1;
        char_valid_q <= do_pop;
        ovf_q        <= ovf_d;
        fill_q       <= cnt_ext[8:0];
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_valid_o = char_valid_q;
  assign char_code_o  = char_valid_q ? rdata_q : 7'h00;
  assign overflow_o   = ovf_q;
  assign fill_level_o = fill_q;

endmodule

### hw/rtl/ps2_scancode_to_ascii_fifo.sv
// Path: input is registered in the 2-entry queue, then in the output registers.
// Throughput: one item per cycle; the front decodes and pushes into a 2-entry
// queue, the back does one character FIFO push or pop per cycle.
// Input stalls only when the queue is full behind a stalled output.
// Reset: async active low; flags, pointers and count clear, FIFO data is not cleared.
module ps2_scancode_to_ascii_fifo import ps2a_pkg::*; #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] char_code_o,
  output logic       overflow_o,
  output logic [8:0] fill_level_o
);

  op_t  front_op, queue_op;
  logic q_full, q_nonempty, take, back_take;

  assign in_stall_o = q_full;
  assign take       = in_valid_i && !q_full;

  ps2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .cmd_i       (cmd_i),
    .scan_byte_i (scan_byte_i),
    .op_o        (front_op)
  );

  ps2a_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .op_i       (front_op),
    .full_o     (q_full),
    .pop_i      (back_take),
    .nonempty_o (q_nonempty),
    .op_o       (queue_op)
  );

  ps2a_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (q_nonempty),
    .op_i         (queue_op),
    .op_take_o    (back_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .overflow_o   (overflow_o),
    .fill_level_o (fill_level_o)
  );

endmodule
